// ===== sv/gyro_adc_scan_average_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GYRO_ADC_SCAN_AVERAGE_DEFINES_SVH
`define GYRO_ADC_SCAN_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GASA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GASA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gasa_pkg.sv =====
package gasa_pkg;

	localparam int SAMPLE_W        = 10;
	localparam int SUM_W           = 16;
	localparam int AVG_W           = 10;
	localparam int BIAS_W          = 11;
	localparam int SEL_W           = 6;
	localparam int NEG_W           = 3;
	localparam int RATE_W          = 12;
	localparam int AXIS_W          = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 11;
	localparam int NUM_SLOTS       = 5;
	localparam int SLOT_W          = 3;
	localparam int NUM_AXES        = 3;
	localparam int DEF_MAX_SAMPLES = 63;

	localparam logic [SEL_W-1:0] AXIS_SELECT_RESET = 6'd36;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_LATCH  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIAS0  = 3'd0,
		REG_BIAS1  = 3'd1,
		REG_BIAS2  = 3'd2,
		REG_AXSEL  = 3'd3,
		REG_NEGATE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Scan slot (position 0..4 in the scan 0,1,2,6,7) holding the channel
	// for average j: gyro 0..2 come from channels 1,2,0, references from 7,6.
	function automatic logic [SLOT_W-1:0] avg_slot(input logic [SLOT_W-1:0] j);
		logic [SLOT_W-1:0] s;
		case (j)
			3'd0:    s = 3'd1;
			3'd1:    s = 3'd2;
			3'd2:    s = 3'd0;
			3'd3:    s = 3'd4;
			3'd4:    s = 3'd3;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/gasa_ifs.sv =====
interface gasa_in_if;
	import gasa_pkg::*;
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [SAMPLE_W-1:0] sample;
	modport source  (output valid, output opcode, output sample, input ready);
	modport sink    (input valid, input opcode, input sample, output ready);
	modport monitor (input valid, input opcode, input sample, input ready);
endinterface

interface gasa_out_if;
	import gasa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [AXIS_W-1:0]        axis;
	logic signed [RATE_W-1:0] rate;
	logic                     last;
	modport source  (output valid, output axis, output rate, output last, input ready);
	modport sink    (input valid, input axis, input rate, input last, output ready);
	modport monitor (input valid, input axis, input rate, input last, input ready);
endinterface

interface gasa_cfg_if;
	import gasa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/gasa_div.sv =====
module gasa_div #(
	parameter int DVD_W = gasa_pkg::SUM_W,
	parameter int DVR_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVR_W-1:0]     divisor,
	output logic [DVD_W-1:0]     quotient,
	output gasa_pkg::div_stat_t  stat
);
	import gasa_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVR_W-1:0]  dvr_q;
	logic [DVR_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DVR_W:0] shifted;
	logic [DVR_W:0] diff;
	logic           ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		diff    = shifted - {1'b0, dvr_q};
		ge      = shifted >= {1'b0, dvr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== sv/gyro_adc_scan_average.sv =====
// Channel   Dir  Payload                      Transaction
// samples   in   opcode, sample[9:0]          valid && ready
// results   out  axis[1:0], rate[11:0], last  valid && ready
// cfg       in   index[2:0], data[10:0]       valid && ready (ready always high)
//
// A latch runs five divisions on the shared 16-step restoring divider (a channel with
// zero count skips its division), then one clear and three result loads.
// Reset clears sums, counts, averages, scan position, bias and negate registers, and sets axis select to its default.
// A stalled result holds the sequencer; a sample is taken while the last result waits.
module gyro_adc_scan_average #(
	parameter int MAX_SAMPLES = gasa_pkg::DEF_MAX_SAMPLES
) (
	input  logic clk,
	input  logic arst_n,
	gasa_in_if.sink    samples,
	gasa_out_if.source results,
	gasa_cfg_if.sink   cfg
);
	import gasa_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_DIV_START = 5'b00010,
		ST_DIV_WAIT  = 5'b00100,
		ST_CLEAR     = 5'b01000,
		ST_EMIT      = 5'b10000
	} state_t;

	state_t state_q;

	logic signed [BIAS_W-1:0] bias_q [NUM_AXES];
	logic [SEL_W-1:0]         axis_sel_q;
	logic [NEG_W-1:0]         negate_q;

	logic [SUM_W-1:0]  sum_q [NUM_SLOTS];
	logic [CNT_W-1:0]  cnt_q [NUM_SLOTS];
	logic [SLOT_W-1:0] scan_q;
	logic [AVG_W-1:0]  gyro_avg_q [NUM_AXES];
	logic [AVG_W-1:0]  ref_avg_q [2];
	logic [SLOT_W-1:0] avg_idx_q;
	logic [AXIS_W-1:0] out_idx_q;

	logic                     out_valid_q;
	logic [AXIS_W-1:0]        out_axis_q;
	logic signed [RATE_W-1:0] out_rate_q;
	logic                     out_last_q;

	logic              in_fire;
	logic              out_fire;
	logic [SLOT_W-1:0] rd_slot;
	logic [SUM_W-1:0]  rd_sum;
	logic [CNT_W-1:0]  rd_cnt;
	logic              div_start;
	logic [SUM_W-1:0]  quotient;
	div_stat_t         div_stat;
	logic              out_load;

	logic [1:0]               phys;
	logic [AVG_W-1:0]         gyro_sel;
	logic [AVG_W-1:0]         ref_sel;
	logic signed [BIAS_W-1:0] bias_sel;
	logic signed [RATE_W:0]   diff;
	logic signed [RATE_W:0]   rate_full;

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_fire       = samples.valid && samples.ready;
	assign out_fire      = results.valid && results.ready;

	// One read port on the sums and counts: scan slot when idle, averaging slot otherwise.
	assign rd_slot = (state_q == ST_IDLE) ? scan_q : avg_slot(avg_idx_q);
	assign rd_sum  = sum_q[rd_slot];
	assign rd_cnt  = cnt_q[rd_slot];

	assign div_start = (state_q == ST_DIV_START) && (rd_cnt != '0);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || results.ready);

	gasa_div #(
		.DVD_W (SUM_W),
		.DVR_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_sum),
		.divisor  (rd_cnt),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Corrected rate for the output axis being loaded.
	always_comb begin
		phys = axis_sel_q[2*out_idx_q +: 2];
		if (phys == 2'd3) begin
			phys = 2'd2;
		end
		gyro_sel  = gyro_avg_q[phys];
		ref_sel   = (phys == 2'd2) ? ref_avg_q[1] : ref_avg_q[0];
		bias_sel  = bias_q[phys];
		diff      = $signed({3'b000, gyro_sel}) - $signed({3'b000, ref_sel})
		            - (RATE_W+1)'(bias_sel);
		rate_full = negate_q[out_idx_q] ? -diff : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				bias_q[i] <= '0;
			end
			axis_sel_q <= AXIS_SELECT_RESET;
			negate_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_BIAS0:  bias_q[0]  <= cfg.data;
				REG_BIAS1:  bias_q[1]  <= cfg.data;
				REG_BIAS2:  bias_q[2]  <= cfg.data;
				REG_AXSEL:  axis_sel_q <= cfg.data[SEL_W-1:0];
				REG_NEGATE: negate_q   <= cfg.data[NEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			avg_idx_q   <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			for (int i = 0; i < NUM_AXES; i++) begin
				gyro_avg_q[i] <= '0;
			end
			ref_avg_q[0] <= '0;
			ref_avg_q[1] <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (opcode_t'(samples.opcode) == OP_SAMPLE) begin
							if (rd_cnt < CNT_W'(MAX_SAMPLES)) begin
								sum_q[scan_q] <= rd_sum + SUM_W'(samples.sample);
								cnt_q[scan_q] <= rd_cnt + 1'b1;
							end
							scan_q <= (scan_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : scan_q + 1'b1;
						end else begin
							avg_idx_q <= '0;
							state_q   <= ST_DIV_START;
						end
					end
				end
				ST_DIV_START: begin
					if (rd_cnt != '0) begin
						state_q <= ST_DIV_WAIT;
					end else if (avg_idx_q == SLOT_W'(NUM_SLOTS - 1)) begin
						state_q <= ST_CLEAR;
					end else begin
						avg_idx_q <= avg_idx_q + 1'b1;
					end
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						case (avg_idx_q)
							3'd0:    gyro_avg_q[0] <= quotient[AVG_W-1:0];
							3'd1:    gyro_avg_q[1] <= quotient[AVG_W-1:0];
							3'd2:    gyro_avg_q[2] <= quotient[AVG_W-1:0];
							3'd3:    ref_avg_q[0]  <= quotient[AVG_W-1:0];
							default: ref_avg_q[1]  <= quotient[AVG_W-1:0];
						endcase
						if (avg_idx_q == SLOT_W'(NUM_SLOTS - 1)) begin
							state_q <= ST_CLEAR;
						end else begin
							avg_idx_q <= avg_idx_q + 1'b1;
							state_q   <= ST_DIV_START;
						end
					end
				end
				ST_CLEAR: begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						sum_q[i] <= '0;
						cnt_q[i] <= '0;
					end
					out_idx_q <= '0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						if (out_idx_q == AXIS_W'(NUM_AXES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_axis_q <= out_idx_q;
			out_rate_q <= rate_full[RATE_W-1:0];
			out_last_q <= (out_idx_q == AXIS_W'(NUM_AXES - 1));
		end
	end

	assign results.valid = out_valid_q;
	assign results.axis  = out_axis_q;
	assign results.rate  = out_rate_q;
	assign results.last  = out_last_q;

endmodule

// ===== sv/gasa_checker.sv =====
`include "gyro_adc_scan_average_defines.svh"

module gasa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [gasa_pkg::AXIS_W-1:0]         out_axis,
	input logic signed [gasa_pkg::RATE_W-1:0]  out_rate,
	input logic                                out_last
);
	import gasa_pkg::*;

	// Hold a stalled result.
	`GASA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_axis) && $stable(out_rate) && $stable(out_last),
		"stalled result changed")

	// Last marks the third axis only.
	`GASA_ASSERT_IMPLY(a_last_axis, clk, arst_n, out_valid,
		out_last == (out_axis == AXIS_W'(NUM_AXES - 1)), "last flag does not match axis")

	// While an early result of a latch waits, the sequencer still has results to load.
	`GASA_ASSERT_IMPLY(a_busy_mid_latch, clk, arst_n, out_valid && !out_last, !in_ready,
		"input ready during a latch")

	// After the first result is taken the second is loaded and the third still pends.
	`GASA_ASSERT_NEXT(a_axis_order, clk, arst_n, out_valid && out_ready && out_axis == '0,
		out_valid && out_axis == AXIS_W'(1) && !in_ready, "axis order broken")

endmodule

bind gyro_adc_scan_average gasa_checker u_gasa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_axis  (results.axis),
	.out_rate  (results.rate),
	.out_last  (results.last)
);
